@@ design/block_buffer_cache_lru_assert.svh @@
// Assertion macros shared by the buffer cache modules.
// Needs clk_i and rst_ni in the scope of the using module.
`ifndef BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/bbc_pkg.sv @@
// Shared types and constants for the LRU buffer cache.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;
  localparam int unsigned SlotCount = 16;
  localparam int unsigned BlockBits = 32;
  localparam int unsigned SlotW = $clog2(SlotCount);
  localparam int unsigned LinkDepth = SlotCount + 2;
  localparam int unsigned LinkW = $clog2(LinkDepth);
  localparam logic [LinkW-1:0] HeadAct = LinkW'(SlotCount);
  localparam logic [LinkW-1:0] HeadInact = LinkW'(SlotCount + 1);
  localparam logic [15:0] RefMax = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_GET = 2'd0,
    ACT_PUT = 2'd1,
    ACT_FREE = 2'd2,
    ACT_NOP = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_number;
    logic [3:0]  slot_index;
    logic [4:0]  free_limit;
  } in_item_t;

  typedef struct packed {
    logic [3:0] slot_out;
    logic       hit;
    logic       read_request;
    logic       page_request;
    logic       status;
    logic [4:0] freed_count;
  } out_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    action_e            action;
    logic               found;
    logic [SlotW-1:0]   slot;
    logic [BlockBits-1:0] block;
    logic               put_ok;
    logic [SlotW:0]     limit;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_EXEC = 2'd1,
    BK_WALK = 2'd2
  } back_state_e;
endpackage
`default_nettype wire

@@ design/bbc_front.sv @@
// Front end: tag search and command classification, feeds the back end through a command register.
// Depends on bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbc_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire bbc_pkg::in_item_t      item_i,
  input  wire logic [bbc_pkg::SlotCount-1:0] tag_valid_i,
  input  wire logic [bbc_pkg::SlotCount-1:0][bbc_pkg::BlockBits-1:0] tags_i,
  output bbc_pkg::cmd_t               cmd_o,
  output logic                        cmd_valid_o
);
  import bbc_pkg::*;
  logic [SlotW-1:0] hit_idx;
  logic hit_any;
  logic [BlockBits-1:0] blk;
  cmd_t cmd_d, cmd_q;
  logic v_q;

  assign blk = item_i.block_number[BlockBits-1:0];

  // priority: lowest matching slot
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (tag_valid_i[i] && tags_i[i] == blk) begin
        hit_any = 1'b1;
        hit_idx = SlotW'(i);
      end
    end
  end

  // a put names its slot directly; only a get uses the search
  always_comb begin
    cmd_d.action = action_e'(item_i.action);
    cmd_d.found  = hit_any;
    cmd_d.block  = blk;
    cmd_d.put_ok = ({1'b0, item_i.slot_index} < 5'(SlotCount));
    cmd_d.slot   = (action_e'(item_i.action) == ACT_GET) ? hit_idx
                                                         : SlotW'(item_i.slot_index);
    cmd_d.limit  = (item_i.free_limit > 5'(SlotCount)) ? (SlotW+1)'(SlotCount)
                                                    : (SlotW+1)'(item_i.free_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else v_q <= take_i;
  end
  always_ff @(posedge clk_i) begin
    if (take_i) cmd_q <= cmd_d;
  end
  assign cmd_o = cmd_q;
  assign cmd_valid_o = v_q;
endmodule
`default_nettype wire

@@ design/bbc_back.sv @@
// Back end: list updates, counts and the freemem walk.
// Depends on bbc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
module bbc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire bbc_pkg::cmd_t     cmd_i,
  output logic                   busy_o,
  output logic [bbc_pkg::SlotCount-1:0] tag_valid_o,
  output logic [bbc_pkg::SlotCount-1:0][bbc_pkg::BlockBits-1:0] tags_o,
  output logic                   res_valid_o,
  output bbc_pkg::out_item_t     res_o
);
  import bbc_pkg::*;
  `include "block_buffer_cache_lru_assert.svh"

  logic [LinkDepth-1:0][LinkW-1:0] nxt_q, nxt_d, prv_q, prv_d;
  logic [SlotCount-1:0][15:0] ref_q, ref_d;
  logic [SlotCount-1:0] val_q, val_d, pg_q, pg_d;
  logic [SlotCount-1:0][BlockBits-1:0] tag_q;
  back_state_e st_q, st_d;
  cmd_t c_q;
  logic [LinkW-1:0] node_q, node_d;
  logic [SlotW:0] freed_q, freed_d, steps_q, steps_d;
  out_item_t res_d;
  logic rv_d;
  logic tag_we;
  logic [SlotW-1:0] s;
  logic [LinkW-1:0] tail, sl, n, p, first;
  logic do_move;
  logic [LinkW-1:0] mhead;

  assign tail = prv_q[HeadInact];

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: if (cmd_valid_i) st_d = (cmd_i.action == ACT_FREE) ? BK_WALK : BK_EXEC;
      BK_EXEC: st_d = BK_IDLE;
      BK_WALK: if (!(node_q < LinkW'(SlotCount) && freed_q < c_q.limit &&
                     steps_q < (SlotW+1)'(SlotCount))) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    nxt_d = nxt_q; prv_d = prv_q; ref_d = ref_q; val_d = val_q; pg_d = pg_q;
    node_d = node_q; freed_d = freed_q; steps_d = steps_q;
    res_d = '0; rv_d = 1'b0; tag_we = 1'b0;
    do_move = 1'b0; mhead = HeadAct;
    s = c_q.slot;
    case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          node_d = prv_q[HeadInact];
          freed_d = '0;
          steps_d = '0;
        end
      end
      BK_EXEC: begin
        rv_d = 1'b1;
        case (c_q.action)
          ACT_GET: begin
            if (!c_q.found && tail >= LinkW'(SlotCount)) begin
              res_d.status = 1'b1;
            end else begin
              if (!c_q.found) begin
                s = tail[SlotW-1:0];
                tag_we = 1'b1;
                val_d[s] = 1'b1;
                res_d.read_request = 1'b1;
              end else begin
                res_d.hit = 1'b1;
              end
              if (!pg_q[s]) begin
                pg_d[s] = 1'b1;
                res_d.page_request = 1'b1;
              end
              if (ref_q[s] != RefMax) ref_d[s] = ref_q[s] + 16'd1;
              res_d.slot_out = 4'(s);
              do_move = 1'b1;
            end
          end
          ACT_PUT: begin
            if (c_q.put_ok) begin
              if (ref_q[s] != 16'd0) ref_d[s] = ref_q[s] - 16'd1;
              if (ref_q[s] <= 16'd1) begin
                do_move = 1'b1;
                mhead = HeadInact;
              end
            end
          end
          default: ;
        endcase
      end
      BK_WALK: begin
        if (st_d == BK_IDLE) begin
          rv_d = 1'b1;
          res_d.freed_count = 5'(freed_q);
        end else begin
          if (pg_q[node_q[SlotW-1:0]]) begin
            pg_d[node_q[SlotW-1:0]] = 1'b0;
            val_d[node_q[SlotW-1:0]] = 1'b0;
            freed_d = freed_q + 1'b1;
          end
          node_d = prv_q[node_q];
          steps_d = steps_q + 1'b1;
        end
      end
      default: ;
    endcase
    // unlink then push at head, same semantics as sequential updates
    sl = LinkW'(s);
    n = nxt_q[sl];
    p = prv_q[sl];
    if (do_move) begin
      prv_d[n] = p;
      nxt_d[p] = n;
      first = nxt_d[mhead];
      nxt_d[sl] = first;
      prv_d[first] = sl;
      prv_d[sl] = mhead;
      nxt_d[mhead] = sl;
    end else begin
      first = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      val_q <= '0; pg_q <= '0; ref_q <= '0;
      res_valid_o <= 1'b0;
      for (int i = 0; i < LinkDepth; i++) begin
        nxt_q[i] <= (i == 0) ? HeadInact : (i < SlotCount) ? LinkW'(i - 1) :
                    (i == SlotCount) ? HeadAct : LinkW'(SlotCount - 1);
        prv_q[i] <= (i == SlotCount - 1) ? HeadInact : (i < SlotCount) ? LinkW'(i + 1) :
                    (i == SlotCount) ? HeadAct : LinkW'(0);
      end
    end else begin
      st_q <= st_d;
      nxt_q <= nxt_d; prv_q <= prv_d; ref_q <= ref_d;
      val_q <= val_d; pg_q <= pg_d;
      res_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && cmd_valid_i) c_q <= cmd_i;
    node_q <= node_d; freed_q <= freed_d; steps_q <= steps_d;
    res_o <= res_d;
    if (tag_we) tag_q[s] <= c_q.block;
  end

  assign busy_o = (st_q != BK_IDLE);
  assign tag_valid_o = val_q;
  assign tags_o = tag_q;

  `BBC_ASSERT_IMP(a_cmd_idle, cmd_valid_i, st_q == BK_IDLE, "command while back busy")
  `BBC_ASSERT_NEXT(a_exec_res, st_q == BK_EXEC, res_valid_o, "exec gave no result")
  `BBC_ASSERT_IMP(a_walk_bound, st_q == BK_WALK, steps_q <= (SlotW+1)'(SlotCount),
                  "walk overran")
endmodule
`default_nettype wire

@@ design/block_buffer_cache_lru.sv @@
// LRU buffer cache over 16 slots with active and inactive lists.
// One beat at a time: busy covers the whole item, so the next start is taken
// the cycle after the strobe.
// The freemem pass walks the inactive list from its tail, one slot per cycle.
// Reset (async, rst_ni low): tags invalid, counts zero, all slots on the inactive list.
`timescale 1ns / 1ps
`default_nettype none
module block_buffer_cache_lru (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire bbc_pkg::in_item_t  item_i,
  output logic                    done_o,
  output bbc_pkg::out_item_t      result_o
);
  import bbc_pkg::*;

  cmd_t cmd;
  logic cmd_valid, back_busy, take, pend_q;
  logic [SlotCount-1:0] tv;
  logic [SlotCount-1:0][BlockBits-1:0] tags;

  // busy from accept until the result strobe has been shown
  assign take = start && !busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else if (take) pend_q <= 1'b1;
    else if (done_o) pend_q <= 1'b0;
  end
  assign busy = pend_q;

  bbc_front u_front (
    .clk_i, .rst_ni, .take_i(take), .item_i,
    .tag_valid_i(tv), .tags_i(tags), .cmd_o(cmd), .cmd_valid_o(cmd_valid)
  );

  bbc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .busy_o(back_busy),
    .tag_valid_o(tv), .tags_o(tags), .res_valid_o(done_o), .res_o(result_o)
  );

  `include "block_buffer_cache_lru_assert.svh"
  `BBC_ASSERT_IMP(a_no_cmd_busy, cmd_valid, !back_busy, "command to busy back end")
  `BBC_ASSERT_IMP(a_done_pending, done_o, pend_q, "result without item")
  `BBC_ASSERT_NEXT(a_take_busy, take, busy, "busy not raised")
endmodule
`default_nettype wire

@@ verif/block_buffer_cache_lru_tb.sv @@
// Self-checking bench for the LRU buffer cache: predicts every result from its own
// copy of tags, counts, pages and list links. Depends on bbc_pkg and the design.
`timescale 1ns / 1ps
`default_nettype none
module block_buffer_cache_lru_tb;
  import bbc_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned HAct = 16;
  localparam int unsigned HIn = 17;
  localparam int unsigned Watchdog = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  logic done_o;
  out_item_t result_o;

  block_buffer_cache_lru i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the cache.
  logic [31:0] sh_tag [Slots];
  logic        sh_valid [Slots];
  logic [15:0] sh_refs [Slots];
  logic        sh_page [Slots];
  int unsigned sh_next [Slots+2];
  int unsigned sh_prev [Slots+2];

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 15;
  int unsigned quiet_cycles = 0;
  logic accepted = 1'b0;

  function automatic void list_unlink(int unsigned s);
    sh_prev[sh_next[s]] = sh_prev[s];
    sh_next[sh_prev[s]] = sh_next[s];
  endfunction

  function automatic void list_push(int unsigned s, int unsigned h);
    int unsigned first;
    first = sh_next[h];
    sh_next[s] = first;
    sh_prev[first] = s;
    sh_prev[s] = h;
    sh_next[h] = s;
  endfunction

  function automatic void cache_reset();
    for (int i = 0; i < Slots; i++) begin
      sh_tag[i] = '0; sh_valid[i] = 0; sh_refs[i] = '0; sh_page[i] = 0;
    end
    sh_next[HAct] = HAct; sh_prev[HAct] = HAct;
    sh_next[HIn] = HIn; sh_prev[HIn] = HIn;
    for (int i = 0; i < Slots; i++) list_push(i, HIn);
  endfunction

  // Applies one command to the shadow and returns the outcome it must produce.
  function automatic out_item_t cache_apply(in_item_t it);
    out_item_t r;
    int unsigned s, lim, freed, node, steps, bk;
    bit found;
    r = '0;
    found = 0;
    s = Slots;
    case (action_e'(it.action))
      ACT_GET: begin
        for (int i = 0; i < Slots; i++)
          if (!found && sh_valid[i] && sh_tag[i] == it.block_number) begin
            s = i; found = 1;
          end
        if (!found) begin
          if (sh_prev[HIn] >= Slots) begin
            r.status = 1'b1;
            return r;
          end
          s = sh_prev[HIn];
          sh_tag[s] = it.block_number;
          sh_valid[s] = 1;
          r.read_request = 1'b1;
        end else r.hit = 1'b1;
        if (!sh_page[s]) begin
          sh_page[s] = 1; r.page_request = 1'b1;
        end
        list_unlink(s); list_push(s, HAct);
        if (sh_refs[s] != 16'hFFFF) sh_refs[s]++;
        r.slot_out = 4'(s);
      end
      ACT_PUT: begin
        s = it.slot_index;
        if (sh_refs[s] != 0) sh_refs[s]--;
        if (sh_refs[s] == 0) begin
          list_unlink(s); list_push(s, HIn);
        end
      end
      ACT_FREE: begin
        lim = (it.free_limit > Slots) ? Slots : it.free_limit;
        freed = 0; steps = 0;
        node = sh_prev[HIn];
        while (node < Slots && freed < lim && steps < Slots) begin
          bk = sh_prev[node];
          if (sh_page[node]) begin
            sh_page[node] = 0; sh_valid[node] = 0; freed++;
          end
          node = bk; steps++;
        end
        r.freed_count = 5'(freed);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_cmd(action_e a, logic [31:0] b, logic [3:0] s,
                                        logic [4:0] l);
    in_item_t it;
    it.action = a; it.block_number = b; it.slot_index = s; it.free_limit = l;
    return it;
  endfunction

  // Half the commands are gets, mostly to a small block set so hits and evictions both happen.
  function automatic in_item_t random_cmd();
    in_item_t it;
    int unsigned p;
    it = '0;
    it.block_number = $urandom();
    it.slot_index = 4'($urandom());
    it.free_limit = 5'($urandom_range(0, 31));
    p = $urandom_range(0, 99);
    if (p < 50) begin
      it.action = ACT_GET;
      if ($urandom_range(0, 9) < 7) it.block_number = $urandom_range(0, 23);
    end else if (p < 88) it.action = ACT_PUT;
    else if (p < 96) begin
      it.action = ACT_FREE;
      if ($urandom_range(0, 3) != 0) it.free_limit = 5'($urandom_range(0, 6));
    end else it.action = ACT_NOP;
    return it;
  endfunction

  // Driver: offers the next pending beat at the falling edge, with random gaps.
  // A beat still waiting for acceptance is held unchanged.
  always @(negedge clk_i) begin
    logic hold;
    hold = start && !accepted;
    if (accepted) begin
      // beat was taken at the last rising edge
      expected_q.push_back(cache_apply(item_i));
      void'(pending_q.pop_front());
    end
    if (hold) begin
      // keep offering the same beat
    end else if (rst_ni && pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      item_i <= pending_q[0];
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t e;
    accepted <= rst_ni && start && !busy;
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (e.slot_out != result_o.slot_out) begin
            $error("slot_out exp %0d got %0d", e.slot_out, result_o.slot_out); errors++;
          end
          if (e.hit != result_o.hit) begin
            $error("hit exp %0d got %0d", e.hit, result_o.hit); errors++;
          end
          if (e.read_request != result_o.read_request) begin
            $error("read_request exp %0d got %0d", e.read_request, result_o.read_request);
            errors++;
          end
          if (e.page_request != result_o.page_request) begin
            $error("page_request exp %0d got %0d", e.page_request, result_o.page_request);
            errors++;
          end
          if (e.status != result_o.status) begin
            $error("status exp %0d got %0d", e.status, result_o.status); errors++;
          end
          if (e.freed_count != result_o.freed_count) begin
            $error("freed_count exp %0d got %0d", e.freed_count, result_o.freed_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles > Watchdog) begin
      $display("block_buffer_cache_lru test failed");
      $finish;
    end
  end

  initial begin
    cache_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: extremes of every field, all actions, empty inactive list.
    pending_q.push_back(make_cmd(ACT_GET, 32'hFFFF_FFFF, 4'hF, 5'h1F));
    pending_q.push_back(make_cmd(ACT_GET, 32'h0, 4'h0, 5'h0));
    pending_q.push_back(make_cmd(ACT_GET, 32'hFFFF_FFFF, 4'h0, 5'h0));
    pending_q.push_back(make_cmd(ACT_PUT, 32'hFFFF_FFFF, 4'h5, 5'h1F));
    pending_q.push_back(make_cmd(ACT_NOP, 32'hFFFF_FFFF, 4'hF, 5'h1F));
    pending_q.push_back(make_cmd(ACT_FREE, 32'h0, 4'h0, 5'h0));
    pending_q.push_back(make_cmd(ACT_FREE, 32'hFFFF_FFFF, 4'hF, 5'h1F));
    for (int i = 0; i < 17; i++)
      pending_q.push_back(make_cmd(ACT_GET, 32'h100 + i, 4'(i), 5'(i)));
    pending_q.push_back(make_cmd(ACT_PUT, 32'h0, 4'hF, 5'h10));
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 15 : (ph == 1) ? 68 : 0;
      for (int i = 0; i < 630; i++) pending_q.push_back(random_cmd());
      while (pending_q.size() != 0) @(posedge clk_i);
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("block_buffer_cache_lru test passed");
    else $display("block_buffer_cache_lru test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ block_buffer_cache_lru.f @@
+incdir+design
design/bbc_pkg.sv
design/bbc_front.sv
design/bbc_back.sv
design/block_buffer_cache_lru.sv
verif/block_buffer_cache_lru_tb.sv
